// File: design/pugs_pkg.sv
// Shared types and codes for the upstream grant scheduler.
`timescale 1ns / 1ps

package pugs_pkg;

  // Default store depth and the largest map one frame tick may emit.
  localparam int MAX_ONUS_DEF = 32;
  localparam int RESULT_CAP   = 32;

  // Operation codes of an input word.
  localparam logic [1:0] OP_REPORT  = 2'd0;
  localparam logic [1:0] OP_RANGING = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ONUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRANT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD      = 3'd4;
  localparam int CFG_DATA_W = 24;

  // Input word: one report, ranging reply or frame tick.
  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  onu_id;
    logic [23:0] class2_occupancy;
    logic [23:0] class3_occupancy;
    logic [31:0] round_trip;
  } in_word_t;

  // Output word: one bandwidth map entry.
  typedef struct packed {
    logic [4:0]  entry_onu;
    logic [31:0] entry_round_trip;
    logic [31:0] start_class2;
    logic [23:0] grant_class2;
    logic [31:0] start_class3;
    logic [23:0] grant_class3;
    logic [31:0] frame_sequence;
    logic        last_entry;
  } out_word_t;

endpackage

// File: design/pugs_if.sv
// Valid/ready channels that carry input words and map entry words.
`timescale 1ns / 1ps

interface pugs_in_if import pugs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pugs_out_if import pugs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/pugs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pugs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/pon_upstream_grant_scheduler_core.sv
// Top level of the upstream grant scheduler: stores, sequencer and shared adder.
`timescale 1ns / 1ps
// Reports and ranging replies are written to the stores; in_ready stays high after them,
// except that the reply that completes ranging adds a class-3 preset sweep of one cycle per ONU.
// Once ranging is complete, a frame tick emits one entry per served ONU, each through the
// read, grant, class-3 start and output states and held until taken before the next starts,
// with the one saturating adder used three times per ONU after the registered store read.
// Reset (synchronous, rst_n low) clears all control state; store entries read as zero
// until written, tracked by per-entry valid bits, so no clearing pass is needed.

module pon_upstream_grant_scheduler_core import pugs_pkg::*; #(
  parameter int MAX_ONUS = MAX_ONUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pugs_in_if.sink               in_word,
  pugs_out_if.source            out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = (MAX_ONUS > 1) ? $clog2(MAX_ONUS) : 1;
  localparam int CAP = (MAX_ONUS < RESULT_CAP) ? MAX_ONUS : RESULT_CAP;
  localparam int CW  = (AW > 6) ? AW : 6;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRESET = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_GRANT  = 3'd3;
  localparam logic [2:0] S_S3     = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_WAIT   = 3'd6;

  logic [2:0]  state_r, state_nxt;

  // Configuration registers.
  logic [5:0]  num_onus_r;
  logic [23:0] max_grant_r;
  logic [23:0] high_limit_r;
  logic [23:0] low_limit_r;
  logic [15:0] guard_r;

  // Control state.
  logic [15:0] rng_cnt_r;
  logic        sched_on_r;
  logic [31:0] seq_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic        split_r;
  logic [MAX_ONUS-1:0] v2_r, v3_r, vrtt_r;
  logic        vb2_r, vb3_r, vbrtt_r;

  // Datapath registers.
  logic [31:0] cursor_r, s2_r, s3_r;
  logic [23:0] g2_r, g3_r;
  out_word_t   out_r;
  logic        out_valid_r;

  // Store ports.
  logic          c2_we, c3_we, rtt_we;
  logic [AW-1:0] wr_addr;
  logic [23:0]   c3_wdata;
  logic [23:0]   c2_rdata, c3_rdata;
  logic [31:0]   rtt_rdata;

  // Combinational helpers.
  logic [5:0]  served_n;
  logic [15:0] rng_cnt_inc;
  logic        in_acc, out_acc, id_ok, idx_last;
  logic [AW-1:0] id_addr;
  logic [23:0] c2_val, c3_val, lim2, lim3;
  logic        split_now;
  logic [31:0] add_a, add_b, add_y;
  logic [32:0] add_sum;

  assign in_acc  = in_word.valid & in_word.ready;
  assign out_acc = out_valid_r & out_word.ready;

  assign in_word.ready  = (state_r == S_IDLE);
  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_r;

  // Served ONU count clamped to one up to the store and map size.
  always_comb begin
    if (num_onus_r == 6'd0) begin
      served_n = 6'd1;
    end else if (32'(num_onus_r) > CAP) begin
      served_n = 6'(CAP);
    end else begin
      served_n = num_onus_r;
    end
  end

  assign idx_last    = (CW'(idx_r) == CW'(served_n - 6'd1));
  assign id_ok       = (32'(in_word.data.onu_id) < MAX_ONUS);
  assign id_addr     = AW'(in_word.data.onu_id);
  assign rng_cnt_inc = (rng_cnt_r != 16'hFFFF) ? rng_cnt_r + 16'd1 : rng_cnt_r;

  // Store write control: reports and replies in idle, the class-3 preset in the sweep.
  always_comb begin
    c2_we    = 1'b0;
    c3_we    = 1'b0;
    rtt_we   = 1'b0;
    wr_addr  = id_addr;
    c3_wdata = in_word.data.class3_occupancy;
    if (state_r == S_PRESET) begin
      c3_we    = 1'b1;
      wr_addr  = idx_r;
      c3_wdata = max_grant_r;
    end else if (in_acc && id_ok) begin
      c2_we  = (in_word.data.op == OP_REPORT);
      c3_we  = (in_word.data.op == OP_REPORT);
      rtt_we = (in_word.data.op == OP_RANGING);
    end
  end

  pugs_ram #(.WIDTH(24), .DEPTH(MAX_ONUS)) u_c2_ram (
    .clk   (clk),
    .we    (c2_we),
    .waddr (wr_addr),
    .wdata (in_word.data.class2_occupancy),
    .raddr (idx_r),
    .rdata (c2_rdata)
  );

  pugs_ram #(.WIDTH(24), .DEPTH(MAX_ONUS)) u_c3_ram (
    .clk   (clk),
    .we    (c3_we),
    .waddr (wr_addr),
    .wdata (c3_wdata),
    .raddr (idx_r),
    .rdata (c3_rdata)
  );

  pugs_ram #(.WIDTH(32), .DEPTH(MAX_ONUS)) u_rtt_ram (
    .clk   (clk),
    .we    (rtt_we),
    .waddr (wr_addr),
    .wdata (in_word.data.round_trip),
    .raddr (idx_r),
    .rdata (rtt_rdata)
  );

  // Backlogs of entries never written read as zero.
  assign c2_val    = vb2_r ? c2_rdata : 24'd0;
  assign c3_val    = vb3_r ? c3_rdata : 24'd0;
  assign split_now = split_r | (c2_val != 24'd0);
  assign lim2      = split_now ? high_limit_r : 24'd0;
  assign lim3      = split_now ? low_limit_r : max_grant_r;

  // Shared saturating adder: guard, class-2 grant and class-3 grant in turn.
  always_comb begin
    case (state_r)
      S_GRANT: begin
        add_a = cursor_r;
        add_b = 32'(guard_r);
      end
      S_S3: begin
        add_a = s2_r;
        add_b = 32'(g2_r);
      end
      default: begin
        add_a = s3_r;
        add_b = 32'(g3_r);
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_y   = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];

  // Sequencer next state and index.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          if (in_word.data.op == OP_RANGING && id_ok && rng_cnt_inc == 16'(served_n)) begin
            state_nxt = S_PRESET;
          end else if (in_word.data.op == OP_TICK && sched_on_r) begin
            state_nxt = S_READ;
          end
        end
      end
      S_PRESET: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ:  state_nxt = S_GRANT;
      S_GRANT: state_nxt = S_S3;
      S_S3:    state_nxt = S_OUT;
      S_OUT:   state_nxt = S_WAIT;
      S_WAIT: begin
        if (out_acc) begin
          if (out_r.last_entry) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_onus_r   <= 6'd1;
      max_grant_r  <= '0;
      high_limit_r <= '0;
      low_limit_r  <= '0;
      guard_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ONUS:   num_onus_r   <= cfg_data[5:0];
        CFG_MAX_GRANT:  max_grant_r  <= cfg_data;
        CFG_HIGH_LIMIT: high_limit_r <= cfg_data;
        CFG_LOW_LIMIT:  low_limit_r  <= cfg_data;
        CFG_GUARD:      guard_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Control state: sequencer, ranging, frame count and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      rng_cnt_r   <= '0;
      sched_on_r  <= 1'b0;
      seq_r       <= '0;
      split_r     <= 1'b0;
      v2_r        <= '0;
      v3_r        <= '0;
      vrtt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (c2_we) begin
        v2_r[wr_addr] <= 1'b1;
      end
      if (c3_we) begin
        v3_r[wr_addr] <= 1'b1;
      end
      if (rtt_we) begin
        vrtt_r[wr_addr] <= 1'b1;
      end
      if (state_r == S_IDLE && in_acc) begin
        if (in_word.data.op == OP_RANGING && id_ok) begin
          rng_cnt_r <= rng_cnt_inc;
          if (rng_cnt_inc == 16'(served_n)) begin
            sched_on_r <= 1'b1;
          end
        end
        if (in_word.data.op == OP_TICK && sched_on_r) begin
          seq_r   <= seq_r + 32'd1;
          split_r <= 1'b0;
        end
      end
      if (state_r == S_GRANT) begin
        split_r <= split_now;
      end
      if (state_r == S_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: cursor, grants, starts and the output register.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      cursor_r <= '0;
    end
    if (state_r == S_READ) begin
      vb2_r   <= v2_r[idx_r];
      vb3_r   <= v3_r[idx_r];
      vbrtt_r <= vrtt_r[idx_r];
    end
    if (state_r == S_GRANT) begin
      g2_r <= (c2_val < lim2) ? c2_val : lim2;
      g3_r <= (c3_val < lim3) ? c3_val : lim3;
      s2_r <= add_y;
    end
    if (state_r == S_S3) begin
      s3_r <= add_y;
    end
    if (state_r == S_OUT) begin
      cursor_r                <= add_y;
      out_r.entry_onu        <= 5'(idx_r);
      out_r.entry_round_trip <= vbrtt_r ? rtt_rdata : 32'd0;
      out_r.start_class2     <= s2_r;
      out_r.grant_class2     <= g2_r;
      out_r.start_class3     <= s3_r;
      out_r.grant_class3     <= g3_r;
      out_r.frame_sequence   <= seq_r;
      out_r.last_entry       <= idx_last;
    end
  end

endmodule

// File: design/pugs_chk.sv
// Port-level checker for the upstream grant scheduler and its bind.
`timescale 1ns / 1ps

module pugs_chk import pugs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic [1:0] in_op,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled map entry word holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("map entry word changed while stalled");

  // No input word is taken while a map entry waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a map entry is pending");

  // Taking the last entry of a map frees the input side in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_entry |=> in_ready && !out_valid)
    else $error("block not idle after the last map entry");

  // Only a frame tick can lead to a map entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op != OP_TICK |=> !out_valid)
    else $error("map entry after a non-tick word");

endmodule

bind pon_upstream_grant_scheduler_core pugs_chk u_pugs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .in_op     (in_word.data.op),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_data  (out_word.data)
);
